@@ hdl/gda_pkg.sv @@
// ----------------------------------------------------------------------------
// gda_pkg: shared types, constants and tables for the date arithmetic block
// Field widths, calendar tables and the operation set of the bit-serial
// divider that the sequencer shares across all divisions.
// ----------------------------------------------------------------------------
package gda_pkg;

  // largest year accepted and produced
  localparam int unsigned MAX_YEAR = 9999;

  // field widths of the stream payloads
  localparam int IN_YEAR_W   = 14;
  localparam int IN_MONTH_W  = 4;
  localparam int IN_DAY_W    = 5;
  localparam int OFFSET_W    = 23;
  localparam int DAY_NUM_W   = 22;
  localparam int WEEKDAY_W   = 3;
  localparam int DOY_W       = 9;
  localparam int NEW_YEAR_W  = 14;
  localparam int NEW_MONTH_W = 4;
  localparam int NEW_DAY_W   = 5;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  localparam int MONTHS = 12;

  // serial day number of 31 December of the last year
  localparam int unsigned LAST_DN =
    365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  // signed width that holds a day number plus any offset
  localparam int unsigned OFF_SPAN = 2 ** (OFFSET_W - 1);
  localparam int DN_W = $clog2(LAST_DN + OFF_SPAN + 1) + 1;

  // width of a shifted year before it is fitted to the output field
  localparam int NY_W = $clog2(MAX_YEAR + 1);

  // quotient bits each division needs
  localparam int QB_Y100 = $clog2(MAX_YEAR / 100 + 1);
  localparam int QB_Y400 = $clog2(MAX_YEAR / 400 + 1);
  localparam int QB_D7   = $clog2(LAST_DN / 7 + 1);
  localparam int QB_C400 = $clog2(LAST_DN / 146097 + 1);
  localparam int QB_C100 = 3;
  localparam int QB_C4   = 5;
  localparam int QB_C1   = 3;

  localparam int CNT_W = $clog2(DN_W + 1);

  // divider operations
  typedef enum logic [2:0] {
    OP_Y100 = 3'd0,
    OP_Y400 = 3'd1,
    OP_D7   = 3'd2,
    OP_C400 = 3'd3,
    OP_C100 = 3'd4,
    OP_C4   = 3'd5,
    OP_C1   = 3'd6
  } div_op_t;

  // sequencer to divider
  typedef struct packed {
    logic    start;
    div_op_t op;
  } div_ctl_t;

  // divider to sequencer
  typedef struct packed {
    logic            done;
    logic [DN_W-1:0] quot;
    logic [DN_W-1:0] rem;
  } div_res_t;

  // divisor moved up to the top quotient bit
  function automatic logic [DN_W-1:0] div_align(input div_op_t op);
    logic [DN_W-1:0] d;
    case (op)
      OP_Y100: d = DN_W'(100) << (QB_Y100 - 1);
      OP_Y400: d = DN_W'(400) << (QB_Y400 - 1);
      OP_D7:   d = DN_W'(7) << (QB_D7 - 1);
      OP_C400: d = DN_W'(146097) << (QB_C400 - 1);
      OP_C100: d = DN_W'(36524) << (QB_C100 - 1);
      OP_C4:   d = DN_W'(1461) << (QB_C4 - 1);
      OP_C1:   d = DN_W'(365) << (QB_C1 - 1);
      default: d = DN_W'(365);
    endcase
    return d;
  endfunction

  // number of quotient bits, one per cycle
  function automatic logic [CNT_W-1:0] div_steps(input div_op_t op);
    logic [CNT_W-1:0] n;
    case (op)
      OP_Y100: n = CNT_W'(QB_Y100);
      OP_Y400: n = CNT_W'(QB_Y400);
      OP_D7:   n = CNT_W'(QB_D7);
      OP_C400: n = CNT_W'(QB_C400);
      OP_C100: n = CNT_W'(QB_C100);
      OP_C4:   n = CNT_W'(QB_C4);
      OP_C1:   n = CNT_W'(QB_C1);
      default: n = CNT_W'(1);
    endcase
    return n;
  endfunction

  // length of a month
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:    n = leap ? 5'd29 : 5'd28;
      4'd4:    n = 5'd30;
      4'd6:    n = 5'd30;
      4'd9:    n = 5'd30;
      4'd11:   n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // days in the months before month m of a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/gregorian_date_arithmetic.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic: date check, day number and date shift
// Converts a proleptic Gregorian date to its serial day number, weekday,
// day of year and leap flag, and gives the date a signed offset away.
// ----------------------------------------------------------------------------
// One item is worked on at a time. Once the input transfer is taken, a date with a
// bad year, month or day code goes straight to the output stage, a day beyond the
// end of its month stops after the day number step, a shifted date outside the
// year range stops after the range test, and any other date runs through every
// division and the month walk; in each case the block then waits while a result is
// still held in the output register. The work is done by one shared bit-serial
// divider that retires one quotient bit per cycle and is used for seven divisions
// per item (by 100 and 400 for the leap test and the year count, by 7 for the
// weekday, and by 146097, 36524, 1461 and 365 to take the shifted day number
// apart), plus a month walk. The next item is taken as soon as the result sits in
// the output register.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_year[13:0], in_month[17:14], in_day[22:18], offset_days[45:23], zeros
  input  logic [gda_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // day_number[21:0], weekday[24:22], day_of_year[33:25], leap_year[34],
  // new_year[48:35], new_month[52:49], new_day[57:53], zeros
  output logic [gda_pkg::OUT_TDATA_W-1:0] out_tdata,
  // date_valid[0], out_of_range[1]
  output logic [gda_pkg::OUT_TUSER_W-1:0] out_tuser
);

  localparam int DN_W = gda_pkg::DN_W;
  localparam int NY_W = gda_pkg::NY_W;
  localparam int QA_W = gda_pkg::QB_C400;
  localparam int Q100_W = gda_pkg::QB_Y100;
  localparam int Q400_W = gda_pkg::QB_Y400;

  // input field positions
  localparam int IY_LSB = 0;
  localparam int IM_LSB = IY_LSB + gda_pkg::IN_YEAR_W;
  localparam int ID_LSB = IM_LSB + gda_pkg::IN_MONTH_W;
  localparam int IO_LSB = ID_LSB + gda_pkg::IN_DAY_W;

  // output field positions
  localparam int DN_LSB = 0;
  localparam int WD_LSB = DN_LSB + gda_pkg::DAY_NUM_W;
  localparam int DY_LSB = WD_LSB + gda_pkg::WEEKDAY_W;
  localparam int LP_LSB = DY_LSB + gda_pkg::DOY_W;
  localparam int NY_LSB = LP_LSB + 1;
  localparam int NM_LSB = NY_LSB + gda_pkg::NEW_YEAR_W;
  localparam int ND_LSB = NM_LSB + gda_pkg::NEW_MONTH_W;
  localparam int NEW_W = gda_pkg::NEW_YEAR_W + gda_pkg::NEW_MONTH_W + gda_pkg::NEW_DAY_W;
  localparam int UB_VLD = 0;
  localparam int UB_OOR = 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_Y100  = 12'b0000_0000_0010,
    S_Y400  = 12'b0000_0000_0100,
    S_DN    = 12'b0000_0000_1000,
    S_D7    = 12'b0000_0001_0000,
    S_SHIFT = 12'b0000_0010_0000,
    S_C400  = 12'b0000_0100_0000,
    S_C100  = 12'b0000_1000_0000,
    S_C4    = 12'b0001_0000_0000,
    S_C1    = 12'b0010_0000_0000,
    S_WALK  = 12'b0100_0000_0000,
    S_EMIT  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // given date
  logic [gda_pkg::IN_YEAR_W-1:0]  year_r;
  logic [gda_pkg::IN_MONTH_W-1:0] month_r;
  logic [gda_pkg::IN_DAY_W-1:0]   day_r;
  logic signed [gda_pkg::OFFSET_W-1:0] off_r;

  // work registers
  logic [DN_W-1:0]   work_r;
  logic [Q100_W-1:0] q100_r;
  logic [Q400_W-1:0] q400_r;
  logic              c100_r;
  logic              c400_r;
  logic [QA_W-1:0]   a_r;
  logic [1:0]        b_r;
  logic [4:0]        c_r;

  // result registers
  logic              vld_r;
  logic              oor_r;
  logic [DN_W-1:0]   dn_r;
  logic [2:0]        wd_r;
  logic [8:0]        doy_r;
  logic              leap_r;
  logic [NY_W-1:0]   ny_r;
  logic              nleap_r;
  logic [3:0]        mo_r;
  logic [8:0]        rd_r;

  logic                            out_tvalid_r;
  logic [gda_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [gda_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  // divider link
  gda_pkg::div_ctl_t div_ctl;
  gda_pkg::div_res_t div_res;
  logic              div_run_r;
  logic              div_state;

  // combinational terms
  logic                            in_fire;
  logic                            out_free;
  logic [gda_pkg::IN_YEAR_W-1:0]   in_year;
  logic [gda_pkg::IN_MONTH_W-1:0]  in_month;
  logic [gda_pkg::IN_DAY_W-1:0]    in_day;
  logic                            bad_code;
  logic [DN_W-1:0]                 p_c;
  logic                            leap_c;
  logic                            day_ok;
  logic [8:0]                      doy_c;
  logic [DN_W-1:0]                 dn_c;
  logic signed [DN_W-1:0]          nsum;
  logic                            n_out;
  logic                            q4;
  logic [1:0]                      e_c;
  logic [NY_W-1:0]                 ny_c;
  logic [4:0]                      mlen;
  logic                            walk_more;
  logic [gda_pkg::OUT_TDATA_W-1:0] pack_data;
  logic [gda_pkg::OUT_TUSER_W-1:0] pack_user;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  assign in_year  = in_tdata[IY_LSB +: gda_pkg::IN_YEAR_W];
  assign in_month = in_tdata[IM_LSB +: gda_pkg::IN_MONTH_W];
  assign in_day   = in_tdata[ID_LSB +: gda_pkg::IN_DAY_W];

  // field codes that can never name a date
  assign bad_code = (in_year == '0) || (32'(in_year) > gda_pkg::MAX_YEAR) ||
                    (in_month == '0) || (in_month > 4'(gda_pkg::MONTHS)) ||
                    (in_day == '0);

  // leap test and day number of the given date
  assign p_c    = DN_W'(year_r) - DN_W'(1);
  assign leap_c = ((p_c[1:0] == 2'b11) && !c100_r) || c400_r;
  assign day_ok = day_r <= gda_pkg::month_len(month_r, leap_c);
  assign doy_c  = gda_pkg::cum_days(month_r) + 9'(day_r) +
                  9'(leap_c && (month_r > 4'd2));
  assign dn_c   = DN_W'(p_c * DN_W'(365)) + (p_c >> 2) - DN_W'(q100_r) +
                  DN_W'(q400_r) + DN_W'(doy_c);

  // shifted day number and range test
  assign nsum  = $signed(dn_r) + DN_W'(off_r);
  assign n_out = nsum[DN_W-1] || (nsum == '0) ||
                 ($unsigned(nsum) > DN_W'(gda_pkg::LAST_DN));

  // century and year counts saturate at the last day of a cycle
  assign q4   = div_res.quot == DN_W'(4);
  assign e_c  = q4 ? 2'd3 : div_res.quot[1:0];
  assign ny_c = NY_W'(NY_W'(400) * NY_W'(a_r)) + NY_W'(NY_W'(100) * NY_W'(b_r)) +
                NY_W'(NY_W'(4) * NY_W'(c_r)) + NY_W'(e_c) + NY_W'(1);

  // month walk
  assign mlen      = gda_pkg::month_len(mo_r, nleap_r);
  assign walk_more = (mo_r < 4'(gda_pkg::MONTHS)) && (rd_r > 9'(mlen));

  // divider operation per state
  always_comb begin
    div_ctl.op = gda_pkg::OP_Y100;
    div_state  = 1'b1;
    case (state_r)
      S_Y100:  div_ctl.op = gda_pkg::OP_Y100;
      S_Y400:  div_ctl.op = gda_pkg::OP_Y400;
      S_D7:    div_ctl.op = gda_pkg::OP_D7;
      S_C400:  div_ctl.op = gda_pkg::OP_C400;
      S_C100:  div_ctl.op = gda_pkg::OP_C100;
      S_C4:    div_ctl.op = gda_pkg::OP_C4;
      S_C1:    div_ctl.op = gda_pkg::OP_C1;
      default: div_state  = 1'b0;
    endcase
    div_ctl.start = div_state && !div_run_r;
  end

  gda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (work_r),
    .res      (div_res)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = bad_code ? S_EMIT : S_Y100;
      S_Y100:  if (div_res.done) state_nxt = S_Y400;
      S_Y400:  if (div_res.done) state_nxt = S_DN;
      S_DN:    state_nxt = day_ok ? S_D7 : S_EMIT;
      S_D7:    if (div_res.done) state_nxt = S_SHIFT;
      S_SHIFT: state_nxt = n_out ? S_EMIT : S_C400;
      S_C400:  if (div_res.done) state_nxt = S_C100;
      S_C100:  if (div_res.done) state_nxt = S_C4;
      S_C4:    if (div_res.done) state_nxt = S_C1;
      S_C1:    if (div_res.done) state_nxt = S_WALK;
      S_WALK:  if (!walk_more) state_nxt = S_EMIT;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      div_run_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (div_ctl.start) begin
        div_run_r <= 1'b1;
      end else if (div_res.done) begin
        div_run_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          year_r  <= in_year;
          month_r <= in_month;
          day_r   <= in_day;
          off_r   <= in_tdata[IO_LSB +: gda_pkg::OFFSET_W];
          work_r  <= DN_W'(in_year) - DN_W'(1);
          vld_r   <= 1'b0;
          oor_r   <= 1'b0;
        end
      end
      S_Y100: begin
        if (div_res.done) begin
          q100_r <= div_res.quot[Q100_W-1:0];
          c100_r <= div_res.rem == DN_W'(99);
        end
      end
      S_Y400: begin
        if (div_res.done) begin
          q400_r <= div_res.quot[Q400_W-1:0];
          c400_r <= div_res.rem == DN_W'(399);
        end
      end
      S_DN: begin
        vld_r  <= day_ok;
        leap_r <= leap_c;
        doy_r  <= doy_c;
        dn_r   <= dn_c;
        work_r <= dn_c;
      end
      S_D7: begin
        if (div_res.done) begin
          wd_r <= div_res.rem[2:0];
        end
      end
      S_SHIFT: begin
        oor_r  <= n_out;
        work_r <= DN_W'($unsigned(nsum) - DN_W'(1));
      end
      S_C400: begin
        if (div_res.done) begin
          a_r    <= div_res.quot[QA_W-1:0];
          work_r <= div_res.rem;
        end
      end
      S_C100: begin
        if (div_res.done) begin
          b_r    <= q4 ? 2'd3 : div_res.quot[1:0];
          work_r <= div_res.rem + (q4 ? DN_W'(36524) : DN_W'(0));
        end
      end
      S_C4: begin
        if (div_res.done) begin
          c_r    <= div_res.quot[4:0];
          work_r <= div_res.rem;
        end
      end
      S_C1: begin
        if (div_res.done) begin
          ny_r    <= ny_c;
          nleap_r <= (e_c == 2'd3) && ((c_r != 5'd24) || (b_r == 2'd3));
          rd_r    <= 9'(div_res.rem + (q4 ? DN_W'(365) : DN_W'(0)) + DN_W'(1));
          mo_r    <= 4'd1;
        end
      end
      S_WALK: begin
        if (walk_more) begin
          rd_r <= rd_r - 9'(mlen);
          mo_r <= mo_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // result packing with zeroed fields for bad dates and shifts out of range
  always_comb begin
    pack_data = '0;
    pack_user = '0;
    if (vld_r) begin
      pack_user[UB_VLD] = 1'b1;
      pack_user[UB_OOR] = oor_r;
      pack_data[DN_LSB +: gda_pkg::DAY_NUM_W] = gda_pkg::DAY_NUM_W'(dn_r);
      pack_data[WD_LSB +: gda_pkg::WEEKDAY_W] = wd_r;
      pack_data[DY_LSB +: gda_pkg::DOY_W]     = doy_r;
      pack_data[LP_LSB]                       = leap_r;
      if (!oor_r) begin
        pack_data[NY_LSB +: gda_pkg::NEW_YEAR_W]  = gda_pkg::NEW_YEAR_W'(ny_r);
        pack_data[NM_LSB +: gda_pkg::NEW_MONTH_W] = mo_r;
        pack_data[ND_LSB +: gda_pkg::NEW_DAY_W]   = gda_pkg::NEW_DAY_W'(rd_r);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && out_free) begin
      out_tdata_r <= pack_data;
      out_tuser_r <= pack_user;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tuser_r[UB_VLD] |->
      (out_tdata_r == '0) && !out_tuser_r[UB_OOR])
    else $error("bad date transfer carries nonzero fields");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r[UB_OOR] |-> out_tdata_r[NY_LSB +: NEW_W] == '0)
    else $error("out of range transfer carries a shifted date");

  a_weekday: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r[UB_VLD] |->
      out_tdata_r[WD_LSB +: gda_pkg::WEEKDAY_W] < 3'd7)
    else $error("weekday out of range");

  a_new_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tuser_r[UB_VLD] && !out_tuser_r[UB_OOR] |->
      (out_tdata_r[NM_LSB +: gda_pkg::NEW_MONTH_W] != '0) &&
      (out_tdata_r[NM_LSB +: gda_pkg::NEW_MONTH_W] <= 4'(gda_pkg::MONTHS)) &&
      (out_tdata_r[ND_LSB +: gda_pkg::NEW_DAY_W] != '0))
    else $error("shifted date has no valid month or day");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_run_r |-> div_state)
    else $error("divider running outside a divide step");

endmodule

@@ hdl/gda_div.sv @@
// ----------------------------------------------------------------------------
// gda_div: bit-serial restoring divider by a calendar constant
// Retires one quotient bit per cycle; the divisor sits in a shift register
// that starts at the top quotient bit and moves down one place each cycle.
// ----------------------------------------------------------------------------
module gda_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  gda_pkg::div_ctl_t        ctl,
  input  logic [gda_pkg::DN_W-1:0] dividend,
  output gda_pkg::div_res_t        res
);

  logic [gda_pkg::DN_W-1:0]  rem_r;
  logic [gda_pkg::DN_W-1:0]  dsr_r;
  logic [gda_pkg::DN_W-1:0]  quot_r;
  logic [gda_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      fit;

  // trial subtract
  assign fit = rem_r >= dsr_r;

  // step counter and handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == gda_pkg::CNT_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= gda_pkg::div_steps(ctl.op);
      end else if (busy_r) begin
        cnt_r <= cnt_r - gda_pkg::CNT_W'(1);
        if (cnt_r == gda_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // remainder, divisor and quotient shift registers
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r  <= dividend;
      dsr_r  <= gda_pkg::div_align(ctl.op);
      quot_r <= '0;
    end else if (busy_r) begin
      if (fit) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r  <= dsr_r >> 1;
      quot_r <= {quot_r[gda_pkg::DN_W-2:0], fit};
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider started while busy");

  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0)
    else $error("divider busy with no steps left");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("divider done while still stepping");

endmodule

@@ tb/gregorian_date_arithmetic_test.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_test: self-checking bench for the date block
// Drives dates and day offsets as stream transfers and compares every
// result, field by field, with a behavioral calendar model or a typed-in expectation. A short
// table covers invalid dates, leap rules and range limits. A random part
// follows that mixes well-formed dates with offsets aimed at the range
// edges and raw noise, with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gregorian_date_arithmetic_test;

  // one date query as it travels on the input stream
  typedef struct packed {
    logic [gda_pkg::IN_YEAR_W-1:0]       year;
    logic [gda_pkg::IN_MONTH_W-1:0]      month;
    logic [gda_pkg::IN_DAY_W-1:0]        day;
    logic signed [gda_pkg::OFFSET_W-1:0] offset;
  } date_query_t;

  // one result: tuser flags first, then the tdata fields
  typedef struct packed {
    logic                            date_valid;
    logic                            out_of_range;
    logic [gda_pkg::DAY_NUM_W-1:0]   day_number;
    logic [gda_pkg::WEEKDAY_W-1:0]   weekday;
    logic [gda_pkg::DOY_W-1:0]       day_of_year;
    logic                            leap_year;
    logic [gda_pkg::NEW_YEAR_W-1:0]  new_year;
    logic [gda_pkg::NEW_MONTH_W-1:0] new_month;
    logic [gda_pkg::NEW_DAY_W-1:0]   new_day;
  } date_result_t;

  // directed table row; known holds a typed-in expectation
  typedef struct {
    date_query_t  q;
    bit           known;
    date_result_t r;
  } date_row_t;

  localparam int RANDOM_QUERIES = 1550;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [gda_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [gda_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [gda_pkg::OUT_TUSER_W-1:0] out_tuser;

  // no idling on either side while set
  logic steady = 1'b0;

  date_result_t pending_dates[$];
  date_row_t    date_table[$];
  int           mismatches = 0;
  int           leftover = 0;

  gregorian_date_arithmetic uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- calendar

  function automatic bit is_leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint days_in_month(input longint y, input longint m);
    case (m)
      2:             return is_leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  // days in all years before year y
  function automatic longint year_start_days(input longint y);
    longint p;
    p = y - 1;
    return 365 * p + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint ordinal_day(input longint y, input longint m, input longint d);
    longint doy;
    doy = d;
    for (longint i = 1; i < m; i++) doy += days_in_month(y, i);
    return doy;
  endfunction

  // expected result of one query
  function automatic date_result_t compute_date_result(input date_query_t q);
    date_result_t r;
    longint y, m, d, off, doy, dn, n, last_dn, ny, nm;
    r = '0;
    y = q.year;
    m = q.month;
    d = q.day;
    off = q.offset;
    if (y < 1 || y > gda_pkg::MAX_YEAR || m < 1 || m > 12 || d < 1 ||
        d > days_in_month(y, m))
      return r;
    doy = ordinal_day(y, m, d);
    dn = year_start_days(y) + doy;
    r.date_valid = 1'b1;
    r.day_number = dn[gda_pkg::DAY_NUM_W-1:0];
    r.weekday = gda_pkg::WEEKDAY_W'(dn % 7);
    r.day_of_year = doy[gda_pkg::DOY_W-1:0];
    r.leap_year = is_leap_year(y);
    // shifted date by exact inverse conversion
    n = dn + off;
    last_dn = year_start_days(longint'(gda_pkg::MAX_YEAR) + 1);
    if (n < 1 || n > last_dn) begin
      r.out_of_range = 1'b1;
      return r;
    end
    ny = ((n - 1) * 400) / 146097 + 1;
    while (year_start_days(ny + 1) < n) ny++;
    while (ny > 1 && year_start_days(ny) >= n) ny--;
    n -= year_start_days(ny);
    nm = 1;
    while (nm < 12 && n > days_in_month(ny, nm)) begin
      n -= days_in_month(ny, nm);
      nm++;
    end
    r.new_year = ny[gda_pkg::NEW_YEAR_W-1:0];
    r.new_month = nm[gda_pkg::NEW_MONTH_W-1:0];
    r.new_day = n[gda_pkg::NEW_DAY_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_row(input longint y, input longint m, input longint d, input longint off,
                         input bit known, input date_result_t r);
    date_row_t row;
    row.q.year = y[gda_pkg::IN_YEAR_W-1:0];
    row.q.month = m[gda_pkg::IN_MONTH_W-1:0];
    row.q.day = d[gda_pkg::IN_DAY_W-1:0];
    row.q.offset = off[gda_pkg::OFFSET_W-1:0];
    row.known = known;
    row.r = r;
    date_table.push_back(row);
  endtask

  // mostly well-formed dates with offsets aimed at the range edges, some noise
  function automatic date_query_t random_query();
    date_query_t q;
    longint y, m, d, len, dn, o, k, last_dn;
    int pick;
    last_dn = year_start_days(longint'(gda_pkg::MAX_YEAR) + 1);
    if ($urandom_range(99) < 25) begin
      q.year = gda_pkg::IN_YEAR_W'($urandom);
      q.month = gda_pkg::IN_MONTH_W'($urandom);
      q.day = gda_pkg::IN_DAY_W'($urandom);
      q.offset = gda_pkg::OFFSET_W'($urandom);
      return q;
    end
    // year: edges, century years, or anywhere
    pick = $urandom_range(9);
    case (pick)
      0:       y = $urandom_range(5, 1);
      1:       y = $urandom_range(gda_pkg::MAX_YEAR, gda_pkg::MAX_YEAR - 4);
      2:       y = 100 * longint'($urandom_range(gda_pkg::MAX_YEAR / 100, 1));
      default: y = $urandom_range(gda_pkg::MAX_YEAR, 1);
    endcase
    m = $urandom_range(12, 1);
    // day: month end, leap day, one past the end, or anywhere
    pick = $urandom_range(9);
    if (pick == 3) m = 2;
    len = days_in_month(y, m);
    case (pick)
      0, 1, 2: d = len;
      3:       d = 29;
      4:       d = len + 1;
      default: d = $urandom_range(len, 1);
    endcase
    dn = year_start_days(y) + ordinal_day(y, m, d);
    k = $urandom_range(6);
    pick = $urandom_range(99);
    if (pick < 30) o = longint'($urandom_range(1600)) - 800;
    else if (pick < 55) o = longint'(signed'(gda_pkg::OFFSET_W'($urandom)));
    else if (pick < 70) o = 1 - dn + k - 3;
    else if (pick < 85) o = last_dn - dn + k - 3;
    else o = 1 - dn + longint'($urandom_range(last_dn - 1));
    q.year = y[gda_pkg::IN_YEAR_W-1:0];
    q.month = m[gda_pkg::IN_MONTH_W-1:0];
    q.day = d[gda_pkg::IN_DAY_W-1:0];
    q.offset = o[gda_pkg::OFFSET_W-1:0];
    return q;
  endfunction

  // one input transfer; the expectation is queued once it is accepted
  task automatic send_query(input date_query_t q, input bit known, input date_result_t r);
    while (!steady && $urandom_range(99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, q.offset, q.day, q.month, q.year};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_dates.push_back(known ? r : compute_date_result(q));
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 33);
    end
  end

  function automatic int check_field(input string name, input longint expd, input longint got);
    if (expd != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, expd, got);
      return 1;
    end
    return 0;
  endfunction

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : result_check
    date_result_t expd;
    date_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[1], out_tdata[21:0], out_tdata[24:22], out_tdata[33:25],
             out_tdata[34], out_tdata[48:35], out_tdata[52:49], out_tdata[57:53]};
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h/%h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        expd = pending_dates.pop_front();
        mismatches += check_field("date_valid", expd.date_valid, got.date_valid);
        mismatches += check_field("out_of_range", expd.out_of_range, got.out_of_range);
        mismatches += check_field("day_number", expd.day_number, got.day_number);
        mismatches += check_field("weekday", expd.weekday, got.weekday);
        mismatches += check_field("day_of_year", expd.day_of_year, got.day_of_year);
        mismatches += check_field("leap_year", expd.leap_year, got.leap_year);
        mismatches += check_field("new_year", expd.new_year, got.new_year);
        mismatches += check_field("new_month", expd.new_month, got.new_month);
        mismatches += check_field("new_day", expd.new_day, got.new_day);
        mismatches += check_field("tdata padding", 0, out_tdata[63:58]);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : main
    date_query_t q;
    int wait_cycles;

    // typed-in rows: first day, last day, both range edges, bad codes
    add_row(1, 1, 1, 0, 1'b1, {1'b1, 1'b0, 22'd1, 3'd1, 9'd1, 1'b0, 14'd1, 4'd1, 5'd1});
    add_row(gda_pkg::MAX_YEAR, 12, 31, 0, 1'b1,
            {1'b1, 1'b0, 22'd3652059, 3'd5, 9'd365, 1'b0, 14'd9999, 4'd12, 5'd31});
    add_row(gda_pkg::MAX_YEAR, 12, 31, 1, 1'b1,
            {1'b1, 1'b1, 22'd3652059, 3'd5, 9'd365, 1'b0, 14'd0, 4'd0, 5'd0});
    add_row(1, 1, 1, -1, 1'b1, {1'b1, 1'b1, 22'd1, 3'd1, 9'd1, 1'b0, 14'd0, 4'd0, 5'd0});
    add_row(0, 1, 1, 5, 1'b1, '0);
    add_row(gda_pkg::MAX_YEAR + 1, 1, 1, 0, 1'b1, '0);
    add_row(16383, 15, 31, -1, 1'b1, '0);
    add_row(0, 0, 0, 0, 1'b1, '0);
    add_row(2024, 0, 10, 0, 1'b1, '0);
    add_row(2024, 13, 1, 0, 1'b1, '0);
    add_row(2024, 3, 0, 0, 1'b1, '0);
    add_row(2023, 4, 31, 0, 1'b1, '0);
    add_row(1900, 2, 29, 0, 1'b1, '0);
    add_row(2000, 2, 30, 0, 1'b1, '0);
    // leap days, year ends and the widest offsets
    add_row(2000, 2, 29, 0, 1'b0, '0);
    add_row(2024, 2, 29, 366, 1'b0, '0);
    add_row(2000, 12, 31, 1, 1'b0, '0);
    add_row(2100, 2, 28, 1, 1'b0, '0);
    add_row(1600, 12, 31, 0, 1'b0, '0);
    add_row(1, 1, 1, 3652058, 1'b0, '0);
    add_row(gda_pkg::MAX_YEAR, 12, 31, -3652058, 1'b0, '0);
    add_row(5000, 6, 15, 4194303, 1'b0, '0);
    add_row(5000, 6, 15, -4194304, 1'b0, '0);
    add_row(1, 12, 31, 59, 1'b0, '0);

    // reset
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (date_table[i]) send_query(date_table[i].q, date_table[i].known, date_table[i].r);

    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      steady <= (i >= 700 && i < 900);
      q = random_query();
      send_query(q, 1'b0, '0);
    end
    in_tvalid <= 1'b0;
    steady <= 1'b0;

    // drain, then give the block time to show any stray result
    wait_cycles = 0;
    while (pending_dates.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (pending_dates.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, pending_dates.size());
      leftover = pending_dates.size();
    end

    if (mismatches == 0 && leftover == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #8000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
